/* hw/rtl/dqtt_pkg.sv */
// Shared types and constants for the DNS query tracking table.
`timescale 1ns / 1ps

package dqtt_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned QID_W  = 16;

   // Item kinds carried in req_tuser
   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_MATCH  = 1'b1;

   // Request tdata layout, lowest bit up
   localparam int unsigned REQ_CLIENT_LSB = 0;
   localparam int unsigned REQ_SERVER_LSB = ADDR_W;
   localparam int unsigned REQ_QID_LSB    = 2 * ADDR_W;
   localparam int unsigned REQ_DATA_W     = 2 * ADDR_W + QID_W;

   // Response tuser layout
   localparam int unsigned RSP_HIT_BIT  = 0;
   localparam int unsigned RSP_DROP_BIT = 1;
   localparam int unsigned RSP_USER_W   = 2;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] client;
      logic [ADDR_W-1:0] server;
      logic [QID_W-1:0]  qid;
   } entry_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic compare;  // register the key compare result
      logic insert;   // shift toward the tail, new entry at cell 0
      logic remove;   // cells at or past the hit take their tail neighbor
   } ctl_type;

endpackage

/* hw/rtl/dqtt_cell.sv */
// One table cell: holds an entry, compares it to the key, shifts with its neighbors.
`timescale 1ns / 1ps

module dqtt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  dqtt_pkg::ctl_type             ctl,
   input  logic                          take,        // at or past the removed entry
   input  dqtt_pkg::entry_type           up_entry,    // from the newer neighbor
   input  dqtt_pkg::entry_type           down_entry,  // from the older neighbor
   input  logic [dqtt_pkg::ADDR_W-1:0]   key_client,
   input  logic [dqtt_pkg::QID_W-1:0]    key_qid,
   output dqtt_pkg::entry_type           entry_ff,
   output logic                          match_ff
);

   dqtt_pkg::entry_type entry_in;
   logic                match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         entry_in = up_entry;
      end else if (ctl.remove && take) begin
         entry_in = down_entry;
      end
      // match bit holds between compares so a stalled commit still sees it
      match_in = match_ff;
      if (ctl.compare) begin
         match_in = entry_ff.valid &&
                    (entry_ff.client == key_client) && (entry_ff.qid == key_qid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         match_ff       <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         match_ff       <= match_in;
      end
      // payload needs no reset, it is never seen while invalid
      entry_ff.client <= entry_in.client;
      entry_ff.server <= entry_in.server;
      entry_ff.qid    <= entry_in.qid;
   end

endmodule

/* hw/rtl/dqtt_prefix.sv */
// Registered log-depth prefix OR over the cell match bits (newest first).
`timescale 1ns / 1ps

module dqtt_prefix #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] bits_in,
   output logic [WIDTH-1:0] prefix_ff
);

   localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] lvl [0:LEVELS];
   logic [WIDTH-1:0] prefix_in;

   assign lvl[0] = bits_in;

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      for (genvar i = 0; i < WIDTH; i++) begin : g_bit
         if (i >= (1 << k)) begin : g_or
            assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
         end else begin : g_pass
            assign lvl[k+1][i] = lvl[k][i];
         end
      end
   end

   assign prefix_in = lvl[LEVELS];

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

endmodule

/* hw/rtl/dns_query_tracking_table.sv */
// Top level of the DNS query tracking table: cell row, sequencer and response register.
`timescale 1ns / 1ps

// A row of TABLE_DEPTH cells holds outstanding queries, newest in cell 0.
// A record beat (req_tuser = 0) inserts client, server and query id at cell 0 and
// pushes older entries one cell toward the tail; if the tail cell is in use the
// table is full, nothing changes and the response flags dropped. A match beat
// (req_tuser = 1) compares every cell against client and query id at once, picks
// the newest hit, returns its server address and closes the gap behind it.
// rsp_tvalid rises after the accepting edge once the sequencer has run its steps:
// cell compare, prefix OR over the match bits, commit. req_tready is high only
// while the sequencer is idle, so no new beat is taken until the last one has
// committed; a response that is not taken holds the commit step until rsp_tready,
// and the cell match bits hold through that wait. A new request is accepted while
// the previous response still waits. Exactly one response beat follows each request beat, in order.
module dns_query_tracking_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [dqtt_pkg::REQ_DATA_W-1:0]       req_tdata,  // client_addr, server_addr, query_id
   input  logic                                  req_tuser,  // mode
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dqtt_pkg::ADDR_W-1:0]           rsp_tdata,  // original_server
   output logic [dqtt_pkg::RSP_USER_W-1:0]       rsp_tuser   // hit, dropped
);

   localparam int AW = dqtt_pkg::ADDR_W;
   localparam int QW = dqtt_pkg::QID_W;

   // sequencer
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CMP    = 2'd1;
   localparam logic [1:0] ST_PFX    = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // latched request
   logic          cmd_mode_ff;
   logic [AW-1:0] cmd_client_ff;
   logic [AW-1:0] cmd_server_ff;
   logic [QW-1:0] cmd_qid_ff;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_drop_ff, rsp_drop_in;
   logic [AW-1:0] rsp_server_ff, rsp_server_in;

   // cell row
   dqtt_pkg::entry_type entry_vec [TABLE_DEPTH];
   dqtt_pkg::entry_type new_entry, empty_entry;
   dqtt_pkg::ctl_type   ctl;
   logic [TABLE_DEPTH-1:0] match_vec;
   logic [TABLE_DEPTH-1:0] take_vec;
   logic [TABLE_DEPTH-1:0] onehot_vec;
   logic [TABLE_DEPTH-1:0] valid_vec;

   logic accept, commit_go, full, hit_any;
   logic [AW-1:0] sel_server;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign commit_go  = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign full       = entry_vec[TABLE_DEPTH-1].valid;
   assign hit_any    = take_vec[TABLE_DEPTH-1];

   assign new_entry   = '{valid: 1'b1, client: cmd_client_ff,
                          server: cmd_server_ff, qid: cmd_qid_ff};
   assign empty_entry = '0;

   always_comb begin
      ctl.compare = (state_ff == ST_CMP) && (cmd_mode_ff == dqtt_pkg::MODE_MATCH);
      ctl.insert  = commit_go && (cmd_mode_ff == dqtt_pkg::MODE_RECORD) && !full;
      ctl.remove  = commit_go && (cmd_mode_ff == dqtt_pkg::MODE_MATCH) && hit_any;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      dqtt_pkg::entry_type up_e, down_e;

      if (i == 0) begin : g_head
         assign up_e = new_entry;
      end else begin : g_up
         assign up_e = entry_vec[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign down_e = empty_entry;
      end else begin : g_down
         assign down_e = entry_vec[i+1];
      end

      dqtt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .take       (take_vec[i]),
         .up_entry   (up_e),
         .down_entry (down_e),
         .key_client (cmd_client_ff),
         .key_qid    (cmd_qid_ff),
         .entry_ff   (entry_vec[i]),
         .match_ff   (match_vec[i])
      );

      assign valid_vec[i] = entry_vec[i].valid;

      // first hit: prefix set here but not one cell newer
      if (i == 0) begin : g_oh0
         assign onehot_vec[i] = take_vec[i];
      end else begin : g_ohn
         assign onehot_vec[i] = take_vec[i] && !take_vec[i-1];
      end
   end

   // take_vec[i]: some cell at index i or newer matched
   dqtt_prefix #(
      .WIDTH (TABLE_DEPTH)
   ) u_prefix (
      .clock     (clock),
      .bits_in   (match_vec),
      .prefix_ff (take_vec)
   );

   // server readout: per-bit OR over the one-hot selected cells
   for (genvar b = 0; b < AW; b++) begin : g_rd
      logic [TABLE_DEPTH-1:0] col;
      for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_col
         assign col[i] = onehot_vec[i] && entry_vec[i].server[b];
      end
      assign sel_server[b] = |col;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP:    state_in = ST_PFX;
         ST_PFX:    state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_server_in = rsp_server_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
         if (cmd_mode_ff == dqtt_pkg::MODE_MATCH) begin
            rsp_hit_in    = hit_any;
            rsp_server_in = sel_server;   // zero on a miss
            rsp_drop_in   = 1'b0;
         end else begin
            rsp_hit_in    = 1'b0;
            rsp_server_in = '0;
            rsp_drop_in   = full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_mode_ff   <= req_tuser;
         cmd_client_ff <= req_tdata[dqtt_pkg::REQ_CLIENT_LSB +: AW];
         cmd_server_ff <= req_tdata[dqtt_pkg::REQ_SERVER_LSB +: AW];
         cmd_qid_ff    <= req_tdata[dqtt_pkg::REQ_QID_LSB +: QW];
      end
      rsp_hit_ff    <= rsp_hit_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_server_ff <= rsp_server_in;
   end

   assign rsp_tvalid                      = rsp_valid_ff;
   assign rsp_tdata                       = rsp_server_ff;
   assign rsp_tuser[dqtt_pkg::RSP_HIT_BIT]  = rsp_hit_ff;
   assign rsp_tuser[dqtt_pkg::RSP_DROP_BIT] = rsp_drop_ff;

   // valid cells always form one run starting at cell 0
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("valid cells not contiguous from the head");

   // a new response only comes out of the commit step
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_COMMIT)
      else $error("response loaded outside commit");

   // an accepted beat always starts the compare step
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CMP)
      else $error("accepted beat did not start compare");

   // at most one cell is picked as the hit
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> $onehot0(onehot_vec))
      else $error("more than one hit cell selected");

endmodule

/* sim/dqtt_checker.sv */
// Checker for the DNS query tracking table: predicts each response beat and compares it.
`timescale 1ns / 1ps

module dqtt_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [dqtt_pkg::REQ_DATA_W-1:0]       req_tdata,  // client_addr, server_addr, query_id
   input  logic                                  req_tuser,  // mode
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [dqtt_pkg::ADDR_W-1:0]           rsp_tdata,  // original_server
   input  logic [dqtt_pkg::RSP_USER_W-1:0]       rsp_tuser,  // hit, dropped
   output int                                    fail_count,
   output int                                    answers_pending
);

   typedef struct packed {
      logic                        hit;
      logic [dqtt_pkg::ADDR_W-1:0] server;
      logic                        dropped;
   } answer_type;

   dqtt_pkg::entry_type query_cells [TABLE_DEPTH];
   answer_type          answers_due [$];
   answer_type          want;
   int                  mismatches = 0;
   int                  due_count  = 0;
   int                  rsp_seen   = 0;

   assign fail_count      = mismatches;
   assign answers_pending = due_count;

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) query_cells[i] = '0;
   end

   // Newest entry in cell 0; valid cells stay packed toward cell 0.
   function automatic answer_type track_query(input logic mode,
                                              input logic [dqtt_pkg::ADDR_W-1:0] client,
                                              input logic [dqtt_pkg::ADDR_W-1:0] server,
                                              input logic [dqtt_pkg::QID_W-1:0] qid);
      answer_type ans;
      int         found;
      int         i;
      ans   = '0;
      found = -1;
      if (mode == dqtt_pkg::MODE_RECORD) begin
         if (query_cells[TABLE_DEPTH-1].valid) begin
            ans.dropped = 1'b1;
         end else begin
            for (i = TABLE_DEPTH - 1; i > 0; i--) query_cells[i] = query_cells[i-1];
            query_cells[0].valid  = 1'b1;
            query_cells[0].client = client;
            query_cells[0].server = server;
            query_cells[0].qid    = qid;
         end
      end else begin
         for (i = 0; i < TABLE_DEPTH; i++) begin
            if (found < 0 && query_cells[i].valid &&
                query_cells[i].client == client && query_cells[i].qid == qid)
               found = i;
         end
         if (found >= 0) begin
            ans.hit    = 1'b1;
            ans.server = query_cells[found].server;
            for (i = found; i < TABLE_DEPTH - 1; i++) query_cells[i] = query_cells[i+1];
            query_cells[TABLE_DEPTH-1] = '0;
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                  input logic [63:0] got_val);
      $display("response %0d: %s expected %h got %h", rsp_seen, what, exp_val, got_val);
      mismatches = mismatches + 1;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("beat with nothing due", 64'd0, {32'd0, rsp_tdata});
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser[dqtt_pkg::RSP_HIT_BIT] !== want.hit)
                  report_mismatch("hit", 64'(want.hit),
                                  64'(rsp_tuser[dqtt_pkg::RSP_HIT_BIT]));
               if (rsp_tdata !== want.server)
                  report_mismatch("original_server", 64'(want.server), 64'(rsp_tdata));
               if (rsp_tuser[dqtt_pkg::RSP_DROP_BIT] !== want.dropped)
                  report_mismatch("dropped", 64'(want.dropped),
                                  64'(rsp_tuser[dqtt_pkg::RSP_DROP_BIT]));
            end
            rsp_seen <= rsp_seen + 1;
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(track_query(req_tuser,
               req_tdata[dqtt_pkg::REQ_CLIENT_LSB +: dqtt_pkg::ADDR_W],
               req_tdata[dqtt_pkg::REQ_SERVER_LSB +: dqtt_pkg::ADDR_W],
               req_tdata[dqtt_pkg::REQ_QID_LSB +: dqtt_pkg::QID_W]));
         due_count <= answers_due.size();
      end
   end

endmodule

/* sim/dns_query_tracking_table_tb.sv */
// Testbench top for the DNS query tracking table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// Directed beats first walk the corner cases: match on an empty table, a stored
// server of zero, all-ones fields, duplicate records (newest goes first), a
// near miss on query id, a full table with a dropped record and a hit in the
// middle of the row. Random phases then run with a small pool of keys per
// phase so that records and matches collide often, first filling the table
// and then draining it. Each phase uses a different mix of sender gaps and
// receiver stalls. The checker beside the block predicts every response.
module dns_query_tracking_table_tb;

   localparam int TABLE_DEPTH    = 16;
   localparam int PHASE_ITEMS    = 106;
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES   = 20;    // block takes a new beat only while its sequencer is idle

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dqtt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // client_addr, server_addr, query_id
   logic                            req_tuser  = 1'b0; // mode
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dqtt_pkg::ADDR_W-1:0]     rsp_tdata;         // original_server
   logic [dqtt_pkg::RSP_USER_W-1:0] rsp_tuser;         // hit, dropped

   int fail_count;
   int answers_pending;
   int send_idle_pct = 0;   // chance per cycle that the sender holds off
   int rsp_stall_pct = 0;   // chance per cycle that the receiver is not ready
   int quiet_cycles  = 0;

   logic [dqtt_pkg::ADDR_W-1:0] client_pool [3];
   logic [dqtt_pkg::QID_W-1:0]  qid_pool    [3];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   dns_query_tracking_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   dqtt_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   // Receiver: one draw per cycle, so stalls land on every step of the
   // block's sequence.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: restarts on any beat; a stuck handshake or a lost response
   // ends the run here.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Drives one request beat and returns at the edge that accepts it. tvalid
   // stays high on return; the next call drives the next beat or the caller lowers it.
   task automatic send_query(input logic mode, input logic [dqtt_pkg::ADDR_W-1:0] client,
                             input logic [dqtt_pkg::ADDR_W-1:0] server,
                             input logic [dqtt_pkg::QID_W-1:0] qid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {qid, server, client};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sender holds off until every response due has been taken.
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
   endtask

   // One random phase: record-heavy in the first half to reach a full table,
   // match-heavy in the second to drain it. One beat in eight carries keys
   // from outside the pool, mostly misses.
   task automatic run_phase(input int idle_pct, input int stall_pct);
      logic                        mode;
      logic [dqtt_pkg::ADDR_W-1:0] client;
      logic [dqtt_pkg::QID_W-1:0]  qid;
      int                          record_pct;
      for (int k = 0; k < 3; k++) begin
         client_pool[k] = $urandom;
         qid_pool[k]    = 16'($urandom);
      end
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         record_pct = (n < PHASE_ITEMS / 2) ? 70 : 35;
         mode   = ($urandom_range(99) < record_pct) ? dqtt_pkg::MODE_RECORD
                                                    : dqtt_pkg::MODE_MATCH;
         client = client_pool[$urandom_range(2)];
         qid    = qid_pool[$urandom_range(2)];
         if ($urandom_range(7) == 0) begin
            client = $urandom;
            qid    = 16'($urandom);
         end
         send_query(mode, client, $urandom, qid);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners, no idling
      send_query(dqtt_pkg::MODE_MATCH, 32'h0, 32'h0, 16'h0);      // empty table: miss
      send_query(dqtt_pkg::MODE_RECORD, 32'h0, 32'h0, 16'h0);     // server of zero
      send_query(dqtt_pkg::MODE_MATCH, 32'h0, 32'h0, 16'h0);      // hit, server 0
      send_query(dqtt_pkg::MODE_RECORD, '1, '1, '1);              // all ones
      send_query(dqtt_pkg::MODE_RECORD, '1, 32'h1234_5678, '1);   // duplicate key
      send_query(dqtt_pkg::MODE_MATCH, '1, 32'h0, '1);            // newest duplicate
      send_query(dqtt_pkg::MODE_MATCH, '1, 32'h0, '1);            // then the older one
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_query(dqtt_pkg::MODE_RECORD, 32'hA5A5_0000 + 32'(i), $urandom, 16'(i));
      send_query(dqtt_pkg::MODE_RECORD, 32'h5A5A_5A5A, $urandom, 16'h5A5A); // full: dropped
      send_query(dqtt_pkg::MODE_MATCH, 32'hA5A5_0003, 32'h0, 16'd4); // client ok, id off: miss
      send_query(dqtt_pkg::MODE_MATCH, 32'hA5A5_0005, 32'h0, 16'd5); // hit mid-row
      wait_for_answers();

      run_phase(0, 0);
      wait_for_answers();
      run_phase(75, 0);
      run_phase(0, 75);
      wait_for_answers();
      run_phase(29, 29);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* dns_query_tracking_table.f */
hw/rtl/dqtt_pkg.sv
hw/rtl/dqtt_cell.sv
hw/rtl/dqtt_prefix.sv
hw/rtl/dns_query_tracking_table.sv
sim/dqtt_checker.sv
sim/dns_query_tracking_table_tb.sv
